// ----- hdl/vstk_pkg.sv -----
package vstk_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned WORD_WIDTH  = 32;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned DEPTH_W     = 8;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(256);

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_PEEK = 2'd2,
    MODE_DROP = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic [31:0]        value;
    logic [DEPTH_W-1:0] depth;
  } vstk_in_t;

  typedef struct packed {
    logic [31:0]      read_data;
    status_e          status;
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] high_water;
  } vstk_out_t;

endpackage

// ----- hdl/vstk_ram.sv -----
module vstk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/value_stack_with_depth_access.sv -----
// Channel | Direction | Handshake              | Beat
// in      | input     | in_valid_i / in_stall_o | vstk_in_t  (mode, value, depth)
// out     | output    | out_valid_o / out_stall_i | vstk_out_t (read_data, status, counts)
// cfg     | input     | cfg_we_i                | 9-bit capacity, no read-back
//
// One item at a time. Push, pop and any error finish in S_EXEC; peek goes on to S_PEEK
// (one registered RAM read), drop at depth d goes on to S_DROP (one entry moved a cycle).
// The result beat is loaded into the output register at the edge that ends the work.
// A beat held in the output register does not stall the input; a finished result
// waiting behind it does, until the output register frees up.
// Async reset empties the stack, clears the high-water mark, sets capacity to 256.
module value_stack_with_depth_access
  import vstk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  vstk_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output vstk_out_t        out_data_o
);

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_PEEK = 5'b00100,
    S_DROP = 5'b01000,
    S_HOLD = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  vstk_in_t         req_q;
  logic [CNT_W-1:0] cap_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] peak_q, peak_d;
  logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;   // next read address during drop
  logic [CNT_W-1:0] wr_ptr_q, wr_ptr_d;   // drop destination
  vstk_out_t        res_q, res_d;         // finished result waiting for the output reg
  vstk_out_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // RAM port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  // datapath helpers
  logic [CNT_W-1:0] usable;
  logic [CNT_W-1:0] dep_ext;
  logic [CNT_W-1:0] at_idx;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;
  logic             dep_bad;
  logic             out_free;
  logic             accept;
  logic             done;

  vstk_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign usable   = (cap_q > CNT_W'(STACK_DEPTH)) ? CNT_W'(STACK_DEPTH) : cap_q;
  assign dep_ext  = {1'b0, req_q.depth};
  assign at_idx   = count_q - CNT_W'(1) - dep_ext;   // entry index, counted from bottom
  assign cnt_inc  = count_q + CNT_W'(1);
  assign cnt_dec  = count_q - CNT_W'(1);
  assign dep_bad  = (dep_ext >= count_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    peak_d      = peak_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[ADDR_W-1:0];
    ram_wdata   = req_q.value;
    ram_raddr   = rd_ptr_q[ADDR_W-1:0];
    done        = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d.read_data   = '0;
        res_d.status      = ST_OK;
        res_d.entry_count = count_q;
        res_d.high_water  = peak_q;
        done              = 1'b1;
        priority if (req_q.mode == MODE_PUSH) begin
          if (count_q >= usable) begin
            res_d.status = ST_OVERFLOW;
          end else begin
            ram_we            = 1'b1;
            count_d           = cnt_inc;
            peak_d            = (cnt_inc > peak_q) ? cnt_inc : peak_q;
            res_d.entry_count = cnt_inc;
            res_d.high_water  = (cnt_inc > peak_q) ? cnt_inc : peak_q;
          end
        end else if (req_q.mode == MODE_POP ||
                     (req_q.mode == MODE_DROP && req_q.depth == '0)) begin
          // drop of the top entry is a plain pop
          if (count_q == '0) begin
            res_d.status = ST_UNDERFLOW;
          end else begin
            count_d           = cnt_dec;
            res_d.entry_count = cnt_dec;
          end
        end else if (dep_bad) begin
          res_d.status = ST_UNDERFLOW;
        end else if (req_q.mode == MODE_PEEK) begin
          ram_raddr = at_idx[ADDR_W-1:0];
          rd_ptr_d  = at_idx;
          done      = 1'b0;
          state_d   = S_PEEK;
        end else begin
          // drop: read at+1 now, then stream one move per cycle
          ram_raddr = at_idx[ADDR_W-1:0] + ADDR_W'(1);
          rd_ptr_d  = at_idx + CNT_W'(2);
          wr_ptr_d  = at_idx;
          done      = 1'b0;
          state_d   = S_DROP;
        end
      end

      S_PEEK: begin
        // read address held, so RAM data stays put while the output is busy
        if (out_free) begin
          out_d.read_data   = ram_rdata;
          out_d.status      = ST_OK;
          out_d.entry_count = count_q;
          out_d.high_water  = peak_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      S_DROP: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr_q[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        rd_ptr_d  = rd_ptr_q + CNT_W'(1);
        wr_ptr_d  = wr_ptr_q + CNT_W'(1);
        if (wr_ptr_q + CNT_W'(2) == count_q) begin
          count_d           = cnt_dec;
          res_d.read_data   = '0;
          res_d.status      = ST_OK;
          res_d.entry_count = cnt_dec;
          res_d.high_water  = peak_q;
          done              = 1'b1;
        end
      end

      S_HOLD: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done) begin
      if (out_free) begin
        out_d       = res_d;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        state_d = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

endmodule

// ----- hdl/vstk_chk.sv -----
module vstk_chk
  import vstk_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input vstk_out_t out_data_o
);

  // one item in flight: after an accept the input side closes
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted again right after an accept");

  a_count_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= out_data_o.high_water)
    else $error("entry count above high-water mark");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.read_data == '0)
    else $error("read data nonzero on error beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

endmodule

bind value_stack_with_depth_access vstk_chk u_vstk_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

// ----- tb/value_stack_with_depth_access_test.sv -----
`timescale 1ns / 1ps

module value_stack_with_depth_access_test;
  import vstk_pkg::*;

  // Directed table: a row either writes the capacity register (only once the
  // block has drained) or sends one beat. Rows flagged 'typed' carry an
  // expectation written out by hand; the rest take the stack predictor's answer.
  typedef enum bit {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    vstk_in_t         item;
    logic [CNT_W-1:0] cap;
    bit               typed;
    vstk_out_t        want;
  } dir_row_t;

  localparam int DIR_ROWS = 29;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty stack: everything but push underflows
    '{ROW_ITEM, '{MODE_POP,  32'h0, 8'd0},   9'd0, 1'b1, '{32'h0, ST_UNDERFLOW, 9'd0, 9'd0}},
    '{ROW_ITEM, '{MODE_PEEK, 32'h0, 8'd0},   9'd0, 1'b1, '{32'h0, ST_UNDERFLOW, 9'd0, 9'd0}},
    '{ROW_ITEM, '{MODE_DROP, 32'h0, 8'd0},   9'd0, 1'b1, '{32'h0, ST_UNDERFLOW, 9'd0, 9'd0}},
    '{ROW_ITEM, '{MODE_DROP, 32'h0, 8'd255}, 9'd0, 1'b1, '{32'h0, ST_UNDERFLOW, 9'd0, 9'd0}},
    // value extremes
    '{ROW_ITEM, '{MODE_PUSH, 32'h0, 8'd0},         9'd0, 1'b1, '{32'h0, ST_OK, 9'd1, 9'd1}},
    '{ROW_ITEM, '{MODE_PUSH, 32'hFFFF_FFFF, 8'd0}, 9'd0, 1'b1, '{32'h0, ST_OK, 9'd2, 9'd2}},
    '{ROW_ITEM, '{MODE_PUSH, 32'h5A5A_C3C3, 8'd0}, 9'd0, 1'b1, '{32'h0, ST_OK, 9'd3, 9'd3}},
    // peek at top, at bottom, one past bottom, max depth
    '{ROW_ITEM, '{MODE_PEEK, 32'h0, 8'd0}, 9'd0, 1'b1, '{32'h5A5A_C3C3, ST_OK, 9'd3, 9'd3}},
    '{ROW_ITEM, '{MODE_PEEK, 32'h0, 8'd2}, 9'd0, 1'b1, '{32'h0, ST_OK, 9'd3, 9'd3}},
    '{ROW_ITEM, '{MODE_PEEK, 32'h0, 8'd3}, 9'd0, 1'b1, '{32'h0, ST_UNDERFLOW, 9'd3, 9'd3}},
    '{ROW_ITEM, '{MODE_PEEK, 32'hFFFF_FFFF, 8'd255}, 9'd0, 1'b1,
      '{32'h0, ST_UNDERFLOW, 9'd3, 9'd3}},
    // drop in the middle closes the gap, drop at zero acts as pop
    '{ROW_ITEM, '{MODE_DROP, 32'h0, 8'd1},         9'd0, 1'b0, '0},
    '{ROW_ITEM, '{MODE_PEEK, 32'h0, 8'd0},         9'd0, 1'b0, '0},
    '{ROW_ITEM, '{MODE_DROP, 32'hFFFF_FFFF, 8'd0}, 9'd0, 1'b0, '0},
    // small capacity, then capacity lowered below the count
    '{ROW_CFG,  '{MODE_PUSH, 32'h0, 8'd0},         9'd2, 1'b0, '0},
    '{ROW_ITEM, '{MODE_PUSH, 32'h0000_1234, 8'd0}, 9'd0, 1'b0, '0},
    '{ROW_ITEM, '{MODE_PUSH, 32'hDEAD_BEEF, 8'd0}, 9'd0, 1'b1,
      '{32'h0, ST_OVERFLOW, 9'd2, 9'd3}},
    '{ROW_CFG,  '{MODE_PUSH, 32'h0, 8'd0},         9'd1, 1'b0, '0},
    '{ROW_ITEM, '{MODE_PUSH, 32'h1111_1111, 8'd0}, 9'd0, 1'b1,
      '{32'h0, ST_OVERFLOW, 9'd2, 9'd3}},
    '{ROW_ITEM, '{MODE_PEEK, 32'h0, 8'd1},         9'd0, 1'b0, '0},
    '{ROW_ITEM, '{MODE_POP,  32'h0, 8'd0},         9'd0, 1'b0, '0},
    '{ROW_ITEM, '{MODE_PUSH, 32'h2222_2222, 8'd0}, 9'd0, 1'b1,
      '{32'h0, ST_OVERFLOW, 9'd1, 9'd3}},
    // capacity zero: every push overflows
    '{ROW_CFG,  '{MODE_PUSH, 32'h0, 8'd0},         9'd0, 1'b0, '0},
    '{ROW_ITEM, '{MODE_POP,  32'h0, 8'd0},         9'd0, 1'b0, '0},
    '{ROW_ITEM, '{MODE_PUSH, 32'hFFFF_FFFF, 8'd0}, 9'd0, 1'b1,
      '{32'h0, ST_OVERFLOW, 9'd0, 9'd3}},
    // capacity past the store depth saturates
    '{ROW_CFG,  '{MODE_PUSH, 32'h0, 8'd0},         9'd511, 1'b0, '0},
    '{ROW_ITEM, '{MODE_PUSH, 32'h8000_0001, 8'd0}, 9'd0, 1'b1, '{32'h0, ST_OK, 9'd1, 9'd3}},
    '{ROW_ITEM, '{MODE_DROP, 32'h0, 8'd0},         9'd0, 1'b0, '0},
    '{ROW_CFG,  '{MODE_PUSH, 32'h0, 8'd0},         9'd256, 1'b0, '0}
  };

  localparam int RANDOM_PHASES  = 6;
  localparam int LONG_HOLD      = 300;  // receiver back-pressure stretch, cycles
  localparam int LONG_HOLD_AT   = 100;  // result count that triggers it
  localparam int DRAIN_PAUSE_AT = 150;  // item in first random phase where sender drains
  localparam int SETTLE_CYCLES  = 8;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  vstk_in_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  vstk_out_t        out_data;

  value_stack_with_depth_access dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk_i = ~clk_i;

  // Predicted stack contents and counters.
  logic [WORD_WIDTH-1:0] stk_mem [STACK_DEPTH];
  int unsigned           stk_count = 0;
  int unsigned           stk_peak = 0;
  logic [CNT_W-1:0]      stk_cap = CAP_RESET;

  vstk_out_t pending_results [$];

  int fail_count = 0;
  int n_items = 0;
  int n_results = 0;
  int n_cap_writes = 0;
  int n_overflow = 0;
  int n_underflow = 0;
  int n_peek_hits = 0;
  int n_drop_hits = 0;

  // Applies one beat to the predicted stack and returns the result beat.
  function automatic vstk_out_t stack_apply(vstk_in_t it);
    vstk_out_t   r;
    mode_e       m;
    int unsigned lim;
    int unsigned at;
    r = '0;
    r.status = ST_OK;
    m = it.mode;
    if (m == MODE_DROP && it.depth == '0) m = MODE_POP;
    lim = (stk_cap > STACK_DEPTH) ? STACK_DEPTH : int'(stk_cap);
    case (m)
      MODE_PUSH: begin
        if (stk_count >= lim) begin
          r.status = ST_OVERFLOW;
        end else begin
          stk_mem[stk_count] = it.value;
          stk_count++;
          if (stk_count > stk_peak) stk_peak = stk_count;
        end
      end
      MODE_POP: begin
        if (stk_count == 0) r.status = ST_UNDERFLOW;
        else stk_count--;
      end
      MODE_PEEK: begin
        if (it.depth >= stk_count) r.status = ST_UNDERFLOW;
        else r.read_data = stk_mem[stk_count - 1 - it.depth];
      end
      default: begin
        if (it.depth >= stk_count) begin
          r.status = ST_UNDERFLOW;
        end else begin
          // entries above the dropped one slide down one slot
          for (at = stk_count - 1 - it.depth; at + 1 < stk_count; at++)
            stk_mem[at] = stk_mem[at + 1];
          stk_count--;
        end
      end
    endcase
    r.entry_count = CNT_W'(stk_count);
    r.high_water  = CNT_W'(stk_peak);
    return r;
  endfunction

  // Random beat; depths mostly land on held entries so peek and drop do real work.
  function automatic vstk_in_t draw_item(int push_pct);
    vstk_in_t    it;
    int unsigned pick;
    it = '0;
    pick = $urandom_range(0, 99);
    if (pick < push_pct) begin
      it.mode = MODE_PUSH;
    end else begin
      case ($urandom_range(0, 3))
        0:       it.mode = MODE_POP;
        1, 2:    it.mode = MODE_PEEK;
        default: it.mode = MODE_DROP;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (stk_count > 0 && pick < 40)
      it.depth = DEPTH_W'($urandom_range(0, (stk_count > 4) ? 3 : stk_count - 1));
    else if (stk_count > 0 && pick < 85)
      it.depth = DEPTH_W'($urandom_range(0, stk_count - 1));
    else
      it.depth = DEPTH_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick == 0) it.value = '0;
    else if (pick == 1) it.value = '1;
    else it.value = $urandom;
    return it;
  endfunction

  // Drive one beat after 'gap' idle cycles, hold it until accepted, then
  // queue its expected result (hand-typed or predicted).
  task automatic send_beat(vstk_in_t it, int gap, bit typed, vstk_out_t want);
    vstk_out_t res;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    res = stack_apply(it);
    pending_results.push_back(typed ? want : res);
    n_items++;
    if (res.status == ST_OVERFLOW) n_overflow++;
    if (res.status == ST_UNDERFLOW) n_underflow++;
    if (res.status == ST_OK && it.mode == MODE_PEEK) n_peek_hits++;
    if (res.status == ST_OK && it.mode == MODE_DROP && it.depth != '0) n_drop_hits++;
  endtask

  // Release the input and wait until every queued result has been taken.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Capacity write; block must be idle, so drain and settle first.
  task automatic write_capacity(logic [CNT_W-1:0] cap);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    stk_cap = cap;
    n_cap_writes++;
  endtask

  // Receiver: a random stall per result, bursty stretches with no stall,
  // and one long hold-off so the block backs up and stalls its input.
  // The checker posts the next hold length; the stall process owns the countdown.
  int rx_hold = 0;
  int rx_next_hold = 0;
  int rx_taken = 0;
  int rx_seen = 0;
  bit rx_burst = 1'b0;

  always @(negedge clk_i) begin
    int hold;
    hold = (rx_taken != rx_seen) ? rx_next_hold : rx_hold;
    rx_seen = rx_taken;
    if (hold > 0) begin
      out_stall <= 1'b1;
      rx_hold   = hold - 1;
    end else begin
      out_stall <= 1'b0;
      rx_hold   = 0;
    end
  end

  always @(posedge clk_i) begin
    vstk_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: %p", out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_data !== want.read_data) begin
          $error("read_data: expected %h, actual %h", want.read_data, out_data.read_data);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count,
                 out_data.entry_count);
          fail_count++;
        end
        if (out_data.high_water !== want.high_water) begin
          $error("high_water: expected %0d, actual %0d", want.high_water,
                 out_data.high_water);
          fail_count++;
        end
      end
      if ($urandom_range(0, 29) == 0) rx_burst = ~rx_burst;
      if (n_results == LONG_HOLD_AT) rx_next_hold = LONG_HOLD;
      else rx_next_hold = rx_burst ? 0 : $urandom_range(0, 5);
      rx_taken++;
    end
  end

  // Watchdog: worst case is ~1000 deep drops plus stalls; the timeout allows
  // several times that.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int               push_pct;
    int               n_phase;
    int               gap;
    bit               tx_burst;
    logic [CNT_W-1:0] cap;
    tx_burst = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_CFG)
        write_capacity(DIR_TABLE[i].cap);
      else
        send_beat(DIR_TABLE[i].item, $urandom_range(0, 5), DIR_TABLE[i].typed,
                  DIR_TABLE[i].want);
    end

    // Random phases: fill to the top, drain under a random capacity, the tiny
    // and zero capacities, saturated capacity, then any 9-bit value.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          cap = 9'd256; push_pct = 85; n_phase = 360;
        end
        1: begin
          cap = CNT_W'($urandom_range(1, 256)); push_pct = 15; n_phase = 250;
        end
        2: begin
          cap = 9'd1; push_pct = 50; n_phase = 60;
        end
        3: begin
          cap = 9'd0; push_pct = 50; n_phase = 40;
        end
        4: begin
          cap = 9'd511; push_pct = 55; n_phase = 150;
        end
        default: begin
          cap = CNT_W'($urandom_range(0, 511)); push_pct = 50; n_phase = 140;
        end
      endcase
      write_capacity(cap);
      for (int k = 0; k < n_phase; k++) begin
        // sender stops once and waits for the block to empty completely
        if (ph == 0 && k == DRAIN_PAUSE_AT) drain_results();
        if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        send_beat(draw_item(push_pct), gap, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES * 4) @(posedge clk_i);

    $display("Ran %0d beats, %0d results, %0d capacity writes; deepest stack %0d.",
             n_items, n_results, n_cap_writes, stk_peak);
    $display("Overflows %0d, underflows %0d, good peeks %0d, mid-stack drops %0d.",
             n_overflow, n_underflow, n_peek_hits, n_drop_hits);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
